// File: sv/sdcb_pkg.sv
// ----------------------------------------------------------------------------
// sdcb_pkg
// Shared types, constants and helper functions of the SATA DMA command builder.
// ----------------------------------------------------------------------------
package sdcb_pkg;

  // Largest number of scatter-gather entries in one command table.
  localparam int MAX_ENTRIES = 63;
  // Largest byte count of one scatter-gather entry.
  localparam int CHUNK_BYTES = 8192;

  localparam int SECTOR_W = 17;
  localparam int SECS_W   = 16;
  localparam int LBA_W    = 48;
  localparam int ADDR_W   = 32;
  localparam int SLOTS    = 32;
  localparam int SLOT_W   = 5;
  localparam int PORT_W   = 5;
  localparam int OP_W     = 8;
  localparam int BM1_W    = 13;
  localparam int CNT_W    = 6;
  localparam int KIND_W   = 2;

  // The byte total of a request is the product of sector count and sector size.
  localparam int TOTAL_W = SECS_W + SECTOR_W;
  // A chunk length holds any value up to CHUNK_BYTES itself.
  localparam int LEN_W   = $clog2(CHUNK_BYTES) + 1;

  localparam logic [TOTAL_W-1:0] MAX_TOTAL  = TOTAL_W'(MAX_ENTRIES * CHUNK_BYTES);
  localparam logic [TOTAL_W-1:0] CHUNK_TOT  = TOTAL_W'(CHUNK_BYTES);
  localparam logic [LEN_W-1:0]   CHUNK_LEN  = LEN_W'(CHUNK_BYTES);
  localparam logic [SECTOR_W-1:0] SECTOR_SIZE_RESET = SECTOR_W'(512);

  localparam logic [OP_W-1:0] OP_READ_DMA_EXT  = 8'h25;
  localparam logic [OP_W-1:0] OP_WRITE_DMA_EXT = 8'h35;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY  = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHECK,
    ST_ENTRY,
    ST_HEADER,
    ST_ERROR
  } state_t;

  // Controls from the sequencer to the datapath.
  typedef struct packed {
    logic  load;
    logic  mul;
    logic  step;
    kind_t res_kind;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic too_big;
    logic zero;
    logic last_chunk;
  } status_t;

  // Lowest clear bit of the busy mask, or slot 0 when every slot is taken.
  function automatic logic [SLOT_W-1:0] first_free_slot(input logic [SLOTS-1:0] busy);
    logic [SLOT_W-1:0] slot;
    slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        slot = SLOT_W'(i);
      end
    end
    return slot;
  endfunction

endpackage

// File: sv/sdcb_req_if.sv
// ----------------------------------------------------------------------------
// sdcb_req_if
// Request channel: one disk transfer request per transaction.
// ----------------------------------------------------------------------------
interface sdcb_req_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [sdcb_pkg::PORT_W-1:0]   port;
  logic [sdcb_pkg::LBA_W-1:0]    start_lba;
  logic [sdcb_pkg::SECS_W-1:0]   sectors;
  logic [sdcb_pkg::ADDR_W-1:0]   buffer_address;
  logic [sdcb_pkg::SLOTS-1:0]    busy_slots;

  modport source (
    output valid, command, port, start_lba, sectors, buffer_address, busy_slots,
    input  ready
  );

  modport sink (
    input  valid, command, port, start_lba, sectors, buffer_address, busy_slots,
    output ready
  );
endinterface

// File: sv/sdcb_res_if.sv
// ----------------------------------------------------------------------------
// sdcb_res_if
// Result channel: scatter-gather entries, command headers and error results.
// ----------------------------------------------------------------------------
interface sdcb_res_if;
  logic                          valid;
  logic                          ready;
  logic [sdcb_pkg::KIND_W-1:0]   kind;
  logic [sdcb_pkg::SLOT_W-1:0]   slot;
  logic [sdcb_pkg::OP_W-1:0]     ata_opcode;
  logic [sdcb_pkg::LBA_W-1:0]    out_lba;
  logic [sdcb_pkg::SECS_W-1:0]   out_sectors;
  logic [sdcb_pkg::PORT_W-1:0]   out_port;
  logic [sdcb_pkg::ADDR_W-1:0]   entry_address;
  logic [sdcb_pkg::BM1_W-1:0]    entry_bytes_minus_one;
  logic                          interrupt_on_done;
  logic [sdcb_pkg::CNT_W-1:0]    entry_count;
  logic                          last;

  modport source (
    output valid, kind, slot, ata_opcode, out_lba, out_sectors, out_port,
           entry_address, entry_bytes_minus_one, interrupt_on_done, entry_count, last,
    input  ready
  );

  modport sink (
    input  valid, kind, slot, ata_opcode, out_lba, out_sectors, out_port,
           entry_address, entry_bytes_minus_one, interrupt_on_done, entry_count, last,
    output ready
  );
endinterface

// File: sv/sdcb_datapath.sv
// ----------------------------------------------------------------------------
// sdcb_datapath
// Request registers, byte-total multiplier and the shared chunk step unit
// that walks the remaining byte count and the buffer address.
// ----------------------------------------------------------------------------
module sdcb_datapath (
  input  logic                            clk,
  input  sdcb_pkg::ctrl_t                 ctrl,
  output sdcb_pkg::status_t               status,
  input  logic [sdcb_pkg::SECTOR_W-1:0]   sector_size,
  input  logic                            req_command,
  input  logic [sdcb_pkg::PORT_W-1:0]     req_port,
  input  logic [sdcb_pkg::LBA_W-1:0]      req_lba,
  input  logic [sdcb_pkg::SECS_W-1:0]     req_sectors,
  input  logic [sdcb_pkg::ADDR_W-1:0]     req_address,
  input  logic [sdcb_pkg::SLOTS-1:0]      req_busy,
  output logic [sdcb_pkg::KIND_W-1:0]     res_kind,
  output logic [sdcb_pkg::SLOT_W-1:0]     res_slot,
  output logic [sdcb_pkg::OP_W-1:0]       res_opcode,
  output logic [sdcb_pkg::LBA_W-1:0]      res_lba,
  output logic [sdcb_pkg::SECS_W-1:0]     res_sectors,
  output logic [sdcb_pkg::PORT_W-1:0]     res_port,
  output logic [sdcb_pkg::ADDR_W-1:0]     res_address,
  output logic [sdcb_pkg::BM1_W-1:0]      res_bytes_minus_one,
  output logic                            res_irq,
  output logic [sdcb_pkg::CNT_W-1:0]      res_count,
  output logic                            res_last
);

  logic                           cmd_r;
  logic [sdcb_pkg::PORT_W-1:0]    port_r;
  logic [sdcb_pkg::LBA_W-1:0]     lba_r;
  logic [sdcb_pkg::SECS_W-1:0]    secs_r;
  logic [sdcb_pkg::ADDR_W-1:0]    addr_r;
  logic [sdcb_pkg::ADDR_W-1:0]    addr_nxt;
  logic [sdcb_pkg::SLOT_W-1:0]    slot_r;
  logic [sdcb_pkg::TOTAL_W-1:0]   rem_r;
  logic [sdcb_pkg::TOTAL_W-1:0]   rem_nxt;
  logic [sdcb_pkg::CNT_W-1:0]     cnt_r;
  logic [sdcb_pkg::TOTAL_W-1:0]   product;
  logic [sdcb_pkg::LEN_W-1:0]     len;
  logic [sdcb_pkg::LEN_W-1:0]     len_m1;
  logic [sdcb_pkg::OP_W-1:0]      opcode;

  // Byte total; the context width of the result keeps the whole product.
  assign product = secs_r * sector_size;

  assign status.too_big    = rem_r > sdcb_pkg::MAX_TOTAL;
  assign status.zero       = rem_r == '0;
  assign status.last_chunk = rem_r <= sdcb_pkg::CHUNK_TOT;

  // One chunk step: the last chunk takes what is left, others take a full chunk.
  assign len      = status.last_chunk ? rem_r[sdcb_pkg::LEN_W-1:0] : sdcb_pkg::CHUNK_LEN;
  assign len_m1   = len - sdcb_pkg::LEN_W'(1);
  assign addr_nxt = addr_r + sdcb_pkg::ADDR_W'(len);
  assign rem_nxt  = rem_r - sdcb_pkg::TOTAL_W'(len);

  assign opcode = cmd_r ? sdcb_pkg::OP_WRITE_DMA_EXT : sdcb_pkg::OP_READ_DMA_EXT;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r  <= req_command;
      port_r <= req_port;
      lba_r  <= req_lba;
      secs_r <= req_sectors;
      addr_r <= req_address;
      slot_r <= sdcb_pkg::first_free_slot(req_busy);
      cnt_r  <= '0;
    end else if (ctrl.step) begin
      addr_r <= addr_nxt;
      cnt_r  <= cnt_r + sdcb_pkg::CNT_W'(1);
    end
    if (ctrl.mul) begin
      rem_r <= product;
    end else if (ctrl.step) begin
      rem_r <= rem_nxt;
    end
  end

  always_comb begin
    res_kind            = ctrl.res_kind;
    res_slot            = '0;
    res_opcode          = '0;
    res_lba             = '0;
    res_sectors         = '0;
    res_port            = '0;
    res_address         = '0;
    res_bytes_minus_one = '0;
    res_irq             = 1'b0;
    res_count           = '0;
    res_last            = 1'b0;
    case (ctrl.res_kind)
      sdcb_pkg::KIND_ENTRY: begin
        res_address         = addr_r;
        res_bytes_minus_one = len_m1[sdcb_pkg::BM1_W-1:0];
        res_irq             = 1'b1;
      end
      sdcb_pkg::KIND_HEADER: begin
        res_slot    = slot_r;
        res_opcode  = opcode;
        res_lba     = lba_r;
        res_sectors = secs_r;
        res_port    = port_r;
        res_count   = cnt_r;
        res_last    = 1'b1;
      end
      sdcb_pkg::KIND_ERROR: begin
        res_slot    = slot_r;
        res_opcode  = opcode;
        res_lba     = lba_r;
        res_sectors = secs_r;
        res_port    = port_r;
        res_last    = 1'b1;
      end
      default: begin
        res_last = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/sdcb_seq.sv
// ----------------------------------------------------------------------------
// sdcb_seq
// Sequencer: accepts a request, runs the multiply and range check, then
// steps the chunk unit once per entry taken and ends with a header or error.
// ----------------------------------------------------------------------------
module sdcb_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  sdcb_pkg::status_t   status,
  output sdcb_pkg::ctrl_t     ctrl
);

  sdcb_pkg::state_t state_r;
  sdcb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sdcb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sdcb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sdcb_pkg::ST_MUL;
      end
      sdcb_pkg::ST_MUL: begin
        state_nxt = sdcb_pkg::ST_CHECK;
      end
      sdcb_pkg::ST_CHECK: begin
        if (status.too_big)   state_nxt = sdcb_pkg::ST_ERROR;
        else if (status.zero) state_nxt = sdcb_pkg::ST_HEADER;
        else                  state_nxt = sdcb_pkg::ST_ENTRY;
      end
      sdcb_pkg::ST_ENTRY: begin
        if (out_ready && status.last_chunk) state_nxt = sdcb_pkg::ST_HEADER;
      end
      sdcb_pkg::ST_HEADER, sdcb_pkg::ST_ERROR: begin
        if (out_ready) state_nxt = sdcb_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = sdcb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    ctrl.load     = 1'b0;
    ctrl.mul      = 1'b0;
    ctrl.step     = 1'b0;
    ctrl.res_kind = sdcb_pkg::KIND_ENTRY;
    case (state_r)
      sdcb_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ctrl.load = in_valid;
      end
      sdcb_pkg::ST_MUL: begin
        ctrl.mul = 1'b1;
      end
      sdcb_pkg::ST_ENTRY: begin
        out_valid     = 1'b1;
        ctrl.step     = out_ready;
        ctrl.res_kind = sdcb_pkg::KIND_ENTRY;
      end
      sdcb_pkg::ST_HEADER: begin
        out_valid     = 1'b1;
        ctrl.res_kind = sdcb_pkg::KIND_HEADER;
      end
      sdcb_pkg::ST_ERROR: begin
        out_valid     = 1'b1;
        ctrl.res_kind = sdcb_pkg::KIND_ERROR;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// File: sv/sata_dma_command_builder_core.sv
// ----------------------------------------------------------------------------
// sata_dma_command_builder_core
// Builds the scatter-gather table and command header of one DMA transfer.
// ----------------------------------------------------------------------------
// A request transaction on in_ch carries direction, port, start LBA, sector
// count, buffer address and the busy-slot mask. The block answers on out_ch
// with one scatter-gather entry per chunk of up to 8192 bytes, in address
// order, followed by one command header with last set. A request that needs
// more than 63 entries yields a single error result instead.
// A request is taken in the idle state, then passes the byte-total multiply
// and the range check; after that each entry and then the header are offered
// on out_ch in turn. The one chunk step unit produces one entry per cycle
// while out_ch is ready. in_ch.ready stays low until the closing result is taken.
// When the receiver stalls, the current result stays on out_ch unchanged and
// the sequencer waits. Reset returns the sequencer to idle and the sector
// size to 512; cfg_wr_en loads the sector size and is meant for idle time.
// ----------------------------------------------------------------------------
module sata_dma_command_builder_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sdcb_pkg::SECTOR_W-1:0]  cfg_wr_data,
  sdcb_req_if.sink                       in_ch,
  sdcb_res_if.source                     out_ch
);

  // Bytes per logical sector of the attached device.
  logic [sdcb_pkg::SECTOR_W-1:0] sector_size_r;

  sdcb_pkg::ctrl_t   ctrl;
  sdcb_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_size_r <= sdcb_pkg::SECTOR_SIZE_RESET;
    end else if (cfg_wr_en) begin
      sector_size_r <= cfg_wr_data;
    end
  end

  // The sequencer holds every result in place until out_ch takes it, so the
  // payload below comes straight from the datapath registers.
  sdcb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .ctrl      (ctrl)
  );

  sdcb_datapath u_datapath (
    .clk                 (clk),
    .ctrl                (ctrl),
    .status              (status),
    .sector_size         (sector_size_r),
    .req_command         (in_ch.command),
    .req_port            (in_ch.port),
    .req_lba             (in_ch.start_lba),
    .req_sectors         (in_ch.sectors),
    .req_address         (in_ch.buffer_address),
    .req_busy            (in_ch.busy_slots),
    .res_kind            (out_ch.kind),
    .res_slot            (out_ch.slot),
    .res_opcode          (out_ch.ata_opcode),
    .res_lba             (out_ch.out_lba),
    .res_sectors         (out_ch.out_sectors),
    .res_port            (out_ch.out_port),
    .res_address         (out_ch.entry_address),
    .res_bytes_minus_one (out_ch.entry_bytes_minus_one),
    .res_irq             (out_ch.interrupt_on_done),
    .res_count           (out_ch.entry_count),
    .res_last            (out_ch.last)
  );

  // The block never offers a result while it is open for a new request.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("request taken while a result is on offer");

  // Once a request is taken the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("ready did not drop after a request transaction");

  // Delivering the final result of a request returns the block to idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> in_ch.ready)
    else $error("block not idle after the final result");

  // Every result that is not an entry closes its request.
  a_last_on_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind != sdcb_pkg::KIND_ENTRY) |-> out_ch.last)
    else $error("header or error result without last");

  // A stalled result stays valid with its kind and entry address held.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.entry_address) && $stable(out_ch.kind)))
    else $error("result changed while stalled");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of sata_dma_command_builder_core. Disk transfer
// requests are driven on the request channel, first from a table of corner
// cases and then at random under several sector-size settings. Every
// accepted request is turned into the scatter-gather entries and the command
// header (or the error result) it ought to produce. Each result transaction
// is checked field by field against those expectations, in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sdcb_pkg::*;

  // Cycles without any transaction on either channel before the run is
  // declared hung. The longest legal quiet stretch is the deliberate receiver
  // hold-off below, plus a configuration pause, so this leaves ample margin.
  localparam int STALL_LIMIT    = 2000;
  // Length of the one long receiver hold-off, used to back the block up.
  localparam int LONG_HOLD      = 300;
  // Result count at which that hold-off begins.
  localparam int HOLD_AFTER     = 200;
  // Settling pause between phases, and the longer one at the end, which
  // covers a full request of 63 entries plus the header and overheads.
  localparam int PHASE_PAUSE    = 8;
  localparam int FINAL_PAUSE    = 80;
  localparam int PHASE_ITEMS    = 46;
  localparam int NUM_PHASES     = 9;
  // Random phase whose sector size is itself drawn at random.
  localparam int RANDOM_SIZE_PHASE = 7;

  // One disk transfer request, as it travels on the request channel.
  typedef struct packed {
    logic                command;
    logic [PORT_W-1:0]   port;
    logic [LBA_W-1:0]    start_lba;
    logic [SECS_W-1:0]   sectors;
    logic [ADDR_W-1:0]   buffer_address;
    logic [SLOTS-1:0]    busy_slots;
  } xfer_req_t;

  // One result transaction, as it ought to appear on the result channel.
  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic [OP_W-1:0]     ata_opcode;
    logic [LBA_W-1:0]    lba;
    logic [SECS_W-1:0]   sectors;
    logic [PORT_W-1:0]   port;
    logic [ADDR_W-1:0]   entry_address;
    logic [BM1_W-1:0]    entry_bytes_minus_one;
    logic                interrupt_on_done;
    logic [CNT_W-1:0]    entry_count;
    logic                last;
  } cmd_result_t;

  // A row of the directed table. Where pinned is set, the kind, slot and
  // entry count of the closing result are written out by hand; they replace
  // those of the computed closing result, so the block is held to them.
  typedef struct packed {
    logic              pinned;
    kind_t             close_kind;
    logic [SLOT_W-1:0] close_slot;
    logic [CNT_W-1:0]  close_count;
    xfer_req_t         req;
  } corner_row_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [SECTOR_W-1:0] cfg_wr_data;

  sdcb_req_if req_ch ();
  sdcb_res_if res_ch ();

  sata_dma_command_builder_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (req_ch),
    .out_ch      (res_ch)
  );

  // Sector size as the testbench believes the block currently holds it.
  logic [SECTOR_W-1:0] sector_size_now;
  // Results still owed by the block, oldest first.
  cmd_result_t table_due[$];
  // Percentage chance of starting an idle burst; shared by both sides.
  int unsigned idle_pct;

  int unsigned failures;
  int unsigned requests_sent;
  int unsigned results_seen;
  int unsigned headers_seen;
  int unsigned errors_seen;
  int unsigned entries_seen;

  // Directed corner cases, all run with the reset sector size of 512 bytes.
  // At 512 bytes a request of 16 sectors is exactly one chunk, 1008 sectors
  // fills all 63 entries, and 1009 sectors is the first that must be refused.
  corner_row_t corner_table [15] = '{
    // Zero-length transfer: a lone header with no entries.
    '{1'b1, KIND_HEADER, 5'd0, 6'd0,
      '{1'b0, 5'd0, 48'h0, 16'd0, 32'h0, 32'h0}},
    // Single short entry starting at the very top of the address space.
    '{1'b1, KIND_HEADER, 5'd0, 6'd1,
      '{1'b1, 5'd31, 48'hFFFF_FFFF_FFFF, 16'd1, 32'hFFFF_FFFF, 32'h0}},
    // Exactly one full chunk.
    '{1'b1, KIND_HEADER, 5'd1, 6'd1,
      '{1'b0, 5'd1, 48'h1, 16'd16, 32'h1000_0000, 32'h1}},
    // One chunk and a little more.
    '{1'b1, KIND_HEADER, 5'd2, 6'd2,
      '{1'b1, 5'd2, 48'h10, 16'd17, 32'h1000_0000, 32'h3}},
    // The largest table, wrapping past the top of the address space.
    '{1'b1, KIND_HEADER, 5'd0, 6'd63,
      '{1'b0, 5'd3, 48'h0000_FFFF_0000, 16'd1008, 32'hFFFF_0000, 32'hFFFF_FFFE}},
    // One sector too many: refused with an error result.
    '{1'b1, KIND_ERROR, 5'd8, 6'd0,
      '{1'b1, 5'd4, 48'h1234_5678_9ABC, 16'd1009, 32'h0, 32'h0000_00FF}},
    // Largest sector count, every slot busy.
    '{1'b1, KIND_ERROR, 5'd0, 6'd0,
      '{1'b0, 5'd31, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    // Only the top slot is free.
    '{1'b1, KIND_HEADER, 5'd31, 6'd1,
      '{1'b1, 5'd5, 48'h0, 16'd5, 32'h0000_0200, 32'h7FFF_FFFF}},
    // Every slot busy on an ordinary request: slot 0 is reported.
    '{1'b1, KIND_HEADER, 5'd0, 6'd1,
      '{1'b0, 5'd6, 48'h0, 16'd5, 32'h0000_0400, 32'hFFFF_FFFF}},
    '{1'b1, KIND_HEADER, 5'd16, 6'd2,
      '{1'b1, 5'd7, 48'h8000_0000_0000, 16'd32, 32'h0001_0000, 32'h0000_FFFF}},
    // The remaining rows are left entirely to the predictor.
    '{1'b0, KIND_ENTRY, 5'd0, 6'd0,
      '{1'b1, 5'd8, 48'h0000_0001_0000, 16'd100, 32'h1234_5678, 32'hA5A5_A5A5}},
    '{1'b0, KIND_ENTRY, 5'd0, 6'd0,
      '{1'b0, 5'd9, 48'hAAAA_AAAA_AAAA, 16'd40, 32'hFFFF_F000, 32'h5555_5555}},
    '{1'b0, KIND_ENTRY, 5'd0, 6'd0,
      '{1'b1, 5'd10, 48'h5555_5555_5555, 16'd33, 32'h0000_0001, 32'hFFFE_FFFF}},
    '{1'b0, KIND_ENTRY, 5'd0, 6'd0,
      '{1'b0, 5'd21, 48'h0000_0000_FFFF, 16'd1007, 32'h8000_0000, 32'h0}},
    '{1'b0, KIND_ENTRY, 5'd0, 6'd0,
      '{1'b1, 5'd0, 48'hFFFF_0000_FFFF, 16'd2, 32'h7FFF_FFFF, 32'h8000_0000}}
  };

  // Sector sizes of the random phases, including the raw values 0 and the
  // full 17-bit field, which lie outside the meaningful range but are legal.
  int unsigned phase_sizes [NUM_PHASES] = '{1, 65536, 4096, 0, 131071, 520, 2048, 1, 512};

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Every mismatch passes through here: it is printed on one line and counted.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                                results_seen, name, got, want));
    end
  endtask

  // Works out the full answer to one request under the current sector size
  // and appends it to the queue of results still owed. The byte total is a
  // 33-bit product, so 64-bit arithmetic is used throughout.
  function automatic void derive_command_table(input xfer_req_t r);
    cmd_result_t          res;
    longint unsigned      total;
    longint unsigned      remaining;
    longint unsigned      chunk_len;
    longint unsigned      chunks;
    logic [ADDR_W-1:0]    addr;
    logic [SLOT_W-1:0]    free_slot;
    logic [OP_W-1:0]      opcode;
    bit                   found;

    total  = longint'(r.sectors) * longint'(sector_size_now);
    chunks = (total + CHUNK_BYTES - 1) / CHUNK_BYTES;

    // Lowest free slot; slot 0 stands when every slot is busy.
    free_slot = '0;
    found     = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (!found && !r.busy_slots[i]) begin
        free_slot = SLOT_W'(i);
        found     = 1'b1;
      end
    end
    opcode = r.command ? OP_WRITE_DMA_EXT : OP_READ_DMA_EXT;

    // The closing result: a header, or an error when the table would not fit.
    res             = '0;
    res.slot        = free_slot;
    res.ata_opcode  = opcode;
    res.lba         = r.start_lba;
    res.sectors     = r.sectors;
    res.port        = r.port;
    res.last        = 1'b1;

    if (chunks > MAX_ENTRIES) begin
      res.kind = KIND_ERROR;
      table_due.push_back(res);
      return;
    end

    res.kind        = KIND_HEADER;
    res.entry_count = CNT_W'(chunks);

    // Entries carry only their address, length and interrupt bit.
    addr      = r.buffer_address;
    remaining = total;
    while (remaining != 0) begin
      cmd_result_t ent;
      chunk_len = (remaining > CHUNK_BYTES) ? CHUNK_BYTES : remaining;
      ent                       = '0;
      ent.kind                  = KIND_ENTRY;
      ent.entry_address         = addr;
      ent.entry_bytes_minus_one = BM1_W'(chunk_len - 1);
      ent.interrupt_on_done     = 1'b1;
      table_due.push_back(ent);
      addr      = addr + ADDR_W'(chunk_len);
      remaining = remaining - chunk_len;
    end
    table_due.push_back(res);
  endfunction

  // Random request, biased towards tables that fit and that are mostly small,
  // with a share of requests right at the fit boundary and beyond it.
  function automatic xfer_req_t random_request();
    xfer_req_t        r;
    int unsigned      fit_cap;
    int unsigned      mode;
    int unsigned      k;
    logic [SLOTS:0]   low_busy;

    r.command   = 1'($urandom_range(0, 1));
    r.port      = PORT_W'($urandom);
    r.start_lba = {16'($urandom), 32'($urandom)};

    if ($urandom_range(0, 4) == 0) begin
      r.buffer_address = 32'hFFFF_FFFF - 32'($urandom_range(0, 65535));
    end else begin
      r.buffer_address = 32'($urandom);
    end

    // Busy mask: fully random, all busy, all free, or a run of busy slots
    // from the bottom so that the free slot lands on a chosen position.
    mode = $urandom_range(0, 99);
    if (mode < 30) begin
      r.busy_slots = 32'($urandom);
    end else if (mode < 40) begin
      r.busy_slots = '1;
    end else if (mode < 50) begin
      r.busy_slots = '0;
    end else begin
      k            = $urandom_range(0, SLOTS - 1);
      low_busy     = (33'(1) << k) - 33'(1);
      r.busy_slots = (32'($urandom) | low_busy[SLOTS-1:0]) & ~(32'(1) << k);
    end

    // Largest sector count whose table still fits at this sector size.
    if (sector_size_now == 0) begin
      fit_cap = 65535;
    end else begin
      fit_cap = (MAX_ENTRIES * CHUNK_BYTES) / sector_size_now;
      if (fit_cap > 65535) fit_cap = 65535;
    end

    mode = $urandom_range(0, 99);
    if (mode < 55) begin
      r.sectors = SECS_W'($urandom_range(0, fit_cap / 8));
    end else if (mode < 70) begin
      r.sectors = SECS_W'($urandom_range(0, fit_cap));
    end else if (mode < 80) begin
      if (fit_cap < 65535 && $urandom_range(0, 1) == 1) begin
        r.sectors = SECS_W'(fit_cap + 1);
      end else begin
        r.sectors = SECS_W'(fit_cap);
      end
    end else if (mode < 90 && fit_cap < 65535) begin
      r.sectors = SECS_W'($urandom_range(fit_cap + 1, 65535));
    end else begin
      r.sectors = SECS_W'($urandom);
    end
    return r;
  endfunction

  // Offers one request, with an optional idle burst in front of it, and
  // returns at the edge on which the request transaction is accepted. Valid
  // is left high so that a following request can follow back to back.
  task automatic send_request(input xfer_req_t r);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.command        <= r.command;
    req_ch.port           <= r.port;
    req_ch.start_lba      <= r.start_lba;
    req_ch.sectors        <= r.sectors;
    req_ch.buffer_address <= r.buffer_address;
    req_ch.busy_slots     <= r.busy_slots;
    do @(posedge clk); while (!req_ch.ready);
    derive_command_table(r);
    requests_sent++;
  endtask

  // Waits until every owed result has arrived, then lets the block settle.
  task automatic drain_results(input int unsigned settle);
    while (table_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // The register is only ever written while the block is idle.
  task automatic load_sector_size(input logic [SECTOR_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
    sector_size_now  = value;
  endtask

  // Result side: checks every accepted result transaction against the
  // oldest owed result and paces ready. Besides the short random bursts, it
  // once holds ready low for a long stretch while requests keep coming, so
  // that the block backs up and holds in_ch.ready low against them.
  task automatic check_result();
    cmd_result_t want;
    results_seen++;
    if (res_ch.kind == KIND_HEADER) headers_seen++;
    if (res_ch.kind == KIND_ERROR) errors_seen++;
    if (res_ch.kind == KIND_ENTRY) entries_seen++;
    if (table_due.size() == 0) begin
      report_mismatch($sformatf("result %0d of kind %0d arrived with nothing owed",
                                results_seen, res_ch.kind));
      return;
    end
    want = table_due.pop_front();
    check_field("kind",                  64'(res_ch.kind),                  64'(want.kind));
    check_field("slot",                  64'(res_ch.slot),                  64'(want.slot));
    check_field("ata_opcode",            64'(res_ch.ata_opcode),            64'(want.ata_opcode));
    check_field("out_lba",               64'(res_ch.out_lba),               64'(want.lba));
    check_field("out_sectors",           64'(res_ch.out_sectors),           64'(want.sectors));
    check_field("out_port",              64'(res_ch.out_port),              64'(want.port));
    check_field("entry_address",         64'(res_ch.entry_address),         64'(want.entry_address));
    check_field("entry_bytes_minus_one", 64'(res_ch.entry_bytes_minus_one),
                64'(want.entry_bytes_minus_one));
    check_field("interrupt_on_done",     64'(res_ch.interrupt_on_done),
                64'(want.interrupt_on_done));
    check_field("entry_count",           64'(res_ch.entry_count),           64'(want.entry_count));
    check_field("last",                  64'(res_ch.last),                  64'(want.last));
  endtask

  initial begin : result_sink
    int unsigned gap;
    int unsigned hold;
    bit          held;
    gap  = 0;
    hold = 0;
    held = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) check_result();
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        hold = LONG_HOLD;
      end
      if (hold != 0) begin
        hold--;
        res_ch.ready <= 1'b0;
      end else if (gap != 0) begin
        gap--;
        res_ch.ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        // This cycle is the first of the burst.
        gap = $urandom_range(1, 4) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Hang detector: the count restarts on any transaction on either channel.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("TIMEOUT: no transaction for %0d cycles, %0d results still owed",
             STALL_LIMIT, table_due.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [SECTOR_W-1:0] size_pick;
    failures      = 0;
    requests_sent = 0;
    results_seen  = 0;
    headers_seen  = 0;
    errors_seen   = 0;
    entries_seen  = 0;
    idle_pct      = 0;
    sector_size_now = SECTOR_SIZE_RESET;

    rst_n                 <= 1'b0;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= SECTOR_SIZE_RESET;
    req_ch.valid          <= 1'b0;
    req_ch.command        <= 1'b0;
    req_ch.port           <= '0;
    req_ch.start_lba      <= '0;
    req_ch.sectors        <= '0;
    req_ch.buffer_address <= '0;
    req_ch.busy_slots     <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corner cases at the reset sector size, with light idling.
    idle_pct = 20;
    foreach (corner_table[i]) begin
      send_request(corner_table[i].req);
      if (corner_table[i].pinned) begin
        table_due[table_due.size() - 1].kind        = corner_table[i].close_kind;
        table_due[table_due.size() - 1].slot        = corner_table[i].close_slot;
        table_due[table_due.size() - 1].entry_count = corner_table[i].close_count;
      end
    end
    req_ch.valid <= 1'b0;
    drain_results(PHASE_PAUSE);

    // Random phases, each under its own sector size. The amount of idling
    // varies from phase to phase and is switched off for the last one.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == RANDOM_SIZE_PHASE) begin
        size_pick = SECTOR_W'($urandom_range(1, 65536));
      end else begin
        size_pick = SECTOR_W'(phase_sizes[p]);
      end
      load_sector_size(size_pick);
      idle_pct = (p == NUM_PHASES - 1) ? 0 : $urandom_range(0, 40);
      repeat (PHASE_ITEMS) send_request(random_request());
      req_ch.valid <= 1'b0;
      drain_results(PHASE_PAUSE);
    end

    drain_results(FINAL_PAUSE);
    if (table_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", table_due.size()));
    end

    $display("Run covered %0d requests over %0d sector-size settings, %0d mismatches.",
             requests_sent, NUM_PHASES + 1, failures);
    $display("Results checked: %0d entries, %0d headers, %0d refusals for oversize tables.",
             entries_seen, headers_seen, errors_seen);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
